// ===== design/bmf_pkg.sv =====
`timescale 1ns / 1ps

package bmf_pkg;

   // Field and register widths
   localparam int PIX_W      = 8;
   localparam int ROW_W      = 10;
   localparam int COL_W      = 10;
   localparam int SIZE_W     = 11;
   localparam int HALF_W     = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int OUT_DATA_W = 32;
   localparam int SIZE_CAP   = 1024;

   // Arithmetic widths
   localparam int HALF_CODES  = 4;   // one column sum per kernel_half code
   localparam int COLSUM_W    = 11;  // up to 7 pixels
   localparam int TOTAL_W     = 14;  // up to 49 pixels
   localparam int RECIP_W     = 21;
   localparam int RECIP_SHIFT = 20;
   localparam int PROD_W      = RECIP_SHIFT + PIX_W;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCOUNT_W    = 3;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_HALF  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd2;

   typedef logic [COLSUM_W-1:0] colsum_type;

   // One pixel column as handed from front to back
   typedef struct packed {
      colsum_type [HALF_CODES-1:0] sums;      // column sum for each kernel size
      logic                        interior;  // window complete, emit a result
      logic [ROW_W-1:0]            out_row;
      logic [COL_W-1:0]            out_col;
      logic                        frame_last;
      logic [HALF_W-1:0]           half;
   } col_entry_type;

   // Reciprocal of k*k scaled by 2^20; exact floor for any 14-bit window sum
   function automatic logic [RECIP_W-1:0] recip(input logic [HALF_W-1:0] half);
      logic [RECIP_W-1:0] r;
      unique case (half)
         2'd0:    r = 21'd1048576;  // 1
         2'd1:    r = 21'd116509;   // 9
         2'd2:    r = 21'd41944;    // 25
         default: r = 21'd21400;    // 49
      endcase
      return r;
   endfunction

endpackage

// ===== design/box_mean_filter.sv =====
`timescale 1ns / 1ps

// Streaming k-by-k box mean filter, k = 2*kernel_half+1, for 8-bit grey
// pixels in raster order.
// req_* takes one pixel per transaction; req_tuser marks the first pixel of
// a frame and clears the row and column counters. rsp_* gives one result
// for each interior pixel (whole window inside the image): the window sum
// divided by k*k, truncated, with its row and column; rsp_tlast flags the
// last result of the frame. Border pixels give no result.
// csr_* writes kernel_half, image_width and image_height; write only while
// no pixel is in flight.
// Throughput: one pixel per clock while rsp_tready is high. The line banks
// give all k rows of a column in one read; the back end keeps a window of
// the newest column sums. A result passes the read stage, the column queue,
// stages A to C and the output register. A 4-entry column queue parts the
// front from the back: when rsp_tready is held low the back end freezes
// with the result held, the queue fills and req_tready drops.
// Reset: kernel_half 1, image 1024 x 1024, position at the frame start,
// pipeline empty. The line banks are not cleared; a frame's results only use
// entries the frame has written itself.

module box_mean_filter #(
   parameter int MAX_KERNEL = 7,
   parameter int MAX_WIDTH  = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   // configuration
   input  logic                              csr_we,
   input  logic [bmf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bmf_pkg::SIZE_W-1:0]        csr_wdata,
   // pixel input
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [bmf_pkg::PIX_W-1:0]         req_tdata,  // [7:0] pixel
   input  logic [0:0]                        req_tuser,  // [0] frame_start
   // filtered output
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [bmf_pkg::OUT_DATA_W-1:0]    rsp_tdata,  // [7:0] filtered,
                                                         // [17:8] out_row,
                                                         // [27:18] out_col
   output logic                              rsp_tlast   // frame_last
);
   import bmf_pkg::*;

   logic                push_valid;
   col_entry_type       push_data;
   logic                pop;
   logic                pop_valid;
   col_entry_type       pop_data;
   logic [QCOUNT_W-1:0] q_count;

   bmf_front #(
      .MAX_KERNEL (MAX_KERNEL),
      .MAX_WIDTH  (MAX_WIDTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .pixel       (req_tdata),
      .frame_start (req_tuser[0]),
      .q_count     (q_count),
      .push_valid  (push_valid),
      .push_data   (push_data)
   );

   bmf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data),
      .count      (q_count)
   );

   bmf_back #(
      .MAX_KERNEL (MAX_KERNEL)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== design/bmf_queue.sv =====
`timescale 1ns / 1ps

module bmf_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   input  bmf_pkg::col_entry_type push_data,
   input  logic                   pop,
   output logic                   pop_valid,
   output bmf_pkg::col_entry_type pop_data,
   output logic [bmf_pkg::QCOUNT_W-1:0] count
);
   import bmf_pkg::*;

   col_entry_type       entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCOUNT_W-1:0] count_ff, count_in;
   logic                pop_ok;

   assign pop_ok    = pop && (count_ff != '0);
   assign pop_valid = (count_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign count     = count_ff;

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = push_valid ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop_ok ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      unique case ({push_valid, pop_ok})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Overflow would drop a column and shift every later window
   assert property (@(posedge clock) disable iff (reset)
      push_valid && !pop_ok |-> count_ff < QCOUNT_W'(QUEUE_DEPTH))
      else $error("column queue overflow");

   // Back side must only take what is there
   assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("column queue read while empty");

endmodule

// ===== design/bmf_front.sv =====
`timescale 1ns / 1ps

module bmf_front #(
   parameter int MAX_KERNEL = 7,
   parameter int MAX_WIDTH  = 1024
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [bmf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bmf_pkg::SIZE_W-1:0]      csr_wdata,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [bmf_pkg::PIX_W-1:0]       pixel,
   input  logic                            frame_start,
   input  logic [bmf_pkg::QCOUNT_W-1:0]    q_count,
   output logic                            push_valid,
   output bmf_pkg::col_entry_type          push_data
);
   import bmf_pkg::*;

   localparam int HALF_LIM = (MAX_KERNEL - 1) / 2;
   localparam int MAX_HALF = (HALF_LIM > 3) ? 3 : HALF_LIM;
   localparam int WCAP     = (MAX_WIDTH < SIZE_CAP) ? MAX_WIDTH : SIZE_CAP;
   localparam int PTR_W    = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
   localparam int ADDR_W   = $clog2(MAX_WIDTH);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(MAX_KERNEL - 1);

   // Configuration registers
   logic [HALF_W-1:0] half_cfg_ff;
   logic [SIZE_W-1:0] width_cfg_ff;
   logic [SIZE_W-1:0] height_cfg_ff;

   // Position state
   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [PTR_W-1:0] ptr_ff, ptr_in;

   // Read stage
   logic                  s1_valid_ff;
   logic [PIX_W-1:0]      s1_pixel_ff;
   logic                  s1_interior_ff;
   logic [ROW_W-1:0]      s1_row_ff;
   logic [COL_W-1:0]      s1_col_ff;
   logic                  s1_last_ff;
   logic [HALF_W-1:0]     s1_half_ff;
   logic [PIX_W-1:0]      rd_ff   [MAX_KERNEL];
   logic [HALF_CODES-1:0] mask_ff [MAX_KERNEL];

   logic              accept;
   logic [SIZE_W-1:0] eff_w, eff_h;
   logic [HALF_W-1:0] eff_half;
   logic [HALF_W:0]   span;
   logic [ROW_W-1:0]  cur_row;
   logic [COL_W-1:0]  cur_col;
   logic [PTR_W-1:0]  cur_ptr;
   logic [PTR_W-1:0]  ptr_next;
   logic              last_col, last_pix, interior;
   logic [ADDR_W-1:0] addr;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         half_cfg_ff   <= HALF_W'(1);
         width_cfg_ff  <= SIZE_W'(SIZE_CAP);
         height_cfg_ff <= SIZE_W'(SIZE_CAP);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_KERNEL_HALF:  half_cfg_ff   <= csr_wdata[HALF_W-1:0];
            CSR_IMAGE_WIDTH:  width_cfg_ff  <= csr_wdata;
            CSR_IMAGE_HEIGHT: height_cfg_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Effective sizes: zero acts as one, oversize is capped
   always_comb begin
      if (width_cfg_ff == '0)                    eff_w = SIZE_W'(1);
      else if (width_cfg_ff > SIZE_W'(WCAP))     eff_w = SIZE_W'(WCAP);
      else                                       eff_w = width_cfg_ff;
      if (height_cfg_ff == '0)                   eff_h = SIZE_W'(1);
      else if (height_cfg_ff > SIZE_W'(SIZE_CAP)) eff_h = SIZE_W'(SIZE_CAP);
      else                                       eff_h = height_cfg_ff;
      eff_half = (half_cfg_ff > HALF_W'(MAX_HALF)) ? HALF_W'(MAX_HALF) : half_cfg_ff;
      span     = {eff_half, 1'b0};
   end

   // Credit against the queue: an item in the read stage holds a slot
   assign req_tready = !reset && ((q_count + QCOUNT_W'(s1_valid_ff)) < QCOUNT_W'(QUEUE_DEPTH));
   assign accept     = req_tvalid && req_tready;

   // Classify the arriving pixel
   always_comb begin
      cur_row  = frame_start ? '0 : row_ff;
      cur_col  = frame_start ? '0 : col_ff;
      cur_ptr  = frame_start ? '0 : ptr_ff;
      ptr_next = (cur_ptr == PTR_LAST) ? '0 : cur_ptr + 1'b1;
      last_col = (SIZE_W'(cur_col) + SIZE_W'(1)) >= eff_w;
      last_pix = last_col && ((SIZE_W'(cur_row) + SIZE_W'(1)) >= eff_h);
      interior = (cur_row >= ROW_W'(span)) && (cur_col >= COL_W'(span)) &&
                 (SIZE_W'(cur_row) < eff_h) && (SIZE_W'(cur_col) < eff_w);
      addr     = ADDR_W'(cur_col);
   end

   // Advance the raster position
   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      ptr_in = ptr_ff;
      if (accept) begin
         priority if (last_pix) begin
            row_in = '0;
            col_in = '0;
            ptr_in = '0;
         end else if (last_col) begin
            row_in = cur_row + 1'b1;
            col_in = '0;
            ptr_in = ptr_next;
         end else begin
            row_in = cur_row;
            col_in = cur_col + 1'b1;
            ptr_in = cur_ptr;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff      <= '0;
         col_ff      <= '0;
         ptr_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         row_ff      <= row_in;
         col_ff      <= col_in;
         ptr_ff      <= ptr_in;
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pixel_ff    <= pixel;
         s1_interior_ff <= interior;
         s1_row_ff      <= cur_row - ROW_W'(eff_half);
         s1_col_ff      <= cur_col - COL_W'(eff_half);
         s1_last_ff     <= last_pix;
         s1_half_ff     <= eff_half;
      end
   end

   // One line bank per row slot; each is read at the arriving column
   for (genvar b = 0; b < MAX_KERNEL; b++) begin : g_bank
      logic [PIX_W-1:0]      mem_ff [MAX_WIDTH];
      logic [PTR_W-1:0]      row_back;
      logic [HALF_CODES-1:0] mask_in;

      // rows back from the arriving row that this bank holds
      always_comb begin
         if (cur_ptr >= PTR_W'(b)) begin
            row_back = cur_ptr - PTR_W'(b);
         end else begin
            row_back = PTR_W'({1'b0, cur_ptr} + (PTR_W + 1)'(MAX_KERNEL - b));
         end
         for (int h = 0; h < HALF_CODES; h++) begin
            mask_in[h] = (row_back != '0) &&
                         (int'(row_back) <= 2 * ((h > MAX_HALF) ? MAX_HALF : h));
         end
      end

      always_ff @(posedge clock) begin
         if (accept) begin
            if (cur_ptr == PTR_W'(b)) begin
               mem_ff[addr] <= pixel;
            end
            rd_ff[b]   <= mem_ff[addr];
            mask_ff[b] <= mask_in;
         end
      end
   end

   // Column sums for every kernel size, pushed to the queue
   always_comb begin
      colsum_type acc;
      push_valid          = s1_valid_ff;
      push_data.interior   = s1_interior_ff;
      push_data.out_row    = s1_row_ff;
      push_data.out_col    = s1_col_ff;
      push_data.frame_last = s1_last_ff;
      push_data.half       = s1_half_ff;
      for (int h = 0; h < HALF_CODES; h++) begin
         acc = COLSUM_W'(s1_pixel_ff);
         for (int b = 0; b < MAX_KERNEL; b++) begin
            if (mask_ff[b][h]) acc = acc + COLSUM_W'(rd_ff[b]);
         end
         push_data.sums[h] = acc;
      end
   end

   // Items in flight never exceed the queue room
   assert property (@(posedge clock) disable iff (reset)
      (QCOUNT_W + 1)'(q_count) + (QCOUNT_W + 1)'(s1_valid_ff) <= (QCOUNT_W + 1)'(QUEUE_DEPTH))
      else $error("front issued beyond queue credit");

endmodule

// ===== design/bmf_back.sv =====
`timescale 1ns / 1ps

module bmf_back #(
   parameter int MAX_KERNEL = 7
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               pop_valid,
   input  bmf_pkg::col_entry_type             pop_data,
   output logic                               pop,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [bmf_pkg::OUT_DATA_W-1:0]     rsp_tdata,
   output logic                               rsp_tlast
);
   import bmf_pkg::*;

   localparam int HALF_LIM = (MAX_KERNEL - 1) / 2;
   localparam int MAX_HALF = (HALF_LIM > 3) ? 3 : HALF_LIM;
   localparam int K_MAX    = 2 * MAX_HALF + 1;
   localparam int FULL_W   = TOTAL_W + RECIP_W;
   localparam int PAD_W    = OUT_DATA_W - PIX_W - ROW_W - COL_W;

   logic en;

   // Column window of the current row, newest first
   colsum_type [HALF_CODES-1:0] line_ff [K_MAX];

   // Stage A: popped column
   logic              a_valid_ff;
   logic              a_interior_ff;
   logic [ROW_W-1:0]  a_row_ff;
   logic [COL_W-1:0]  a_col_ff;
   logic              a_last_ff;
   logic [HALF_W-1:0] a_half_ff;

   // Stage B: window total
   logic               b_valid_ff;
   logic [TOTAL_W-1:0] b_total_ff;
   logic [ROW_W-1:0]   b_row_ff;
   logic [COL_W-1:0]   b_col_ff;
   logic               b_last_ff;
   logic [HALF_W-1:0]  b_half_ff;
   logic [TOTAL_W-1:0] total_in;

   // Stage C: scaled product
   logic              c_valid_ff;
   logic [PROD_W-1:0] c_prod_ff;
   logic [ROW_W-1:0]  c_row_ff;
   logic [COL_W-1:0]  c_col_ff;
   logic              c_last_ff;

   // Output register
   logic                  out_valid_ff;
   logic [OUT_DATA_W-1:0] out_data_ff;
   logic                  out_last_ff;

   // Whole back end moves together unless the result waits
   assign en  = !out_valid_ff || rsp_tready;
   assign pop = en && pop_valid;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff   <= pop_valid;
         b_valid_ff   <= a_valid_ff && a_interior_ff;
         c_valid_ff   <= b_valid_ff;
         out_valid_ff <= c_valid_ff;
      end
   end

   // Shift the new column in
   always_ff @(posedge clock) begin
      if (pop) begin
         line_ff[0]    <= pop_data.sums;
         for (int j = 1; j < K_MAX; j++) begin
            line_ff[j] <= line_ff[j-1];
         end
         a_interior_ff <= pop_data.interior;
         a_row_ff      <= pop_data.out_row;
         a_col_ff      <= pop_data.out_col;
         a_last_ff     <= pop_data.frame_last;
         a_half_ff     <= pop_data.half;
      end
   end

   // Add the k newest columns at the selected kernel size
   always_comb begin
      total_in = '0;
      for (int j = 0; j < K_MAX; j++) begin
         if (j <= 2 * int'(a_half_ff)) begin
            total_in = total_in + TOTAL_W'(line_ff[j][a_half_ff]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_total_ff <= total_in;
         b_row_ff   <= a_row_ff;
         b_col_ff   <= a_col_ff;
         b_last_ff  <= a_last_ff;
         b_half_ff  <= a_half_ff;
      end
   end

   // Divide by k*k through the scaled reciprocal
   always_ff @(posedge clock) begin
      if (en) begin
         c_prod_ff <= PROD_W'(FULL_W'(b_total_ff) * FULL_W'(recip(b_half_ff)));
         c_row_ff  <= b_row_ff;
         c_col_ff  <= b_col_ff;
         c_last_ff <= b_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_data_ff <= {PAD_W'(0), c_col_ff, c_row_ff, c_prod_ff[RECIP_SHIFT +: PIX_W]};
         out_last_ff <= c_last_ff;
      end
   end

   // A window total only follows an interior column in stage A
   assert property (@(posedge clock) disable iff (reset)
      en && !(a_valid_ff && a_interior_ff) |=> !b_valid_ff)
      else $error("window total issued without an interior column");

endmodule
